// File: rtl/amg_pkg.sv
package amg_pkg;

    // Field widths of the request and response transactions
    localparam int OP_W      = 3;
    localparam int VTX_W     = 4;
    localparam int WEIGHT_W  = 16;
    localparam int MARK_W    = 8;
    localparam int COUNT_W   = 5;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register word index (paddr[2]) of the vertex count register
    localparam logic REG_VERTEX_COUNT = 1'b0;

    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_SET_EDGE    = 3'd0,
        OP_REMOVE_EDGE = 3'd1,
        OP_QUERY_EDGE  = 3'd2,
        OP_FIRST_NBR   = 3'd3,
        OP_NEXT_NBR    = 3'd4,
        OP_READ_MARK   = 3'd5,
        OP_WRITE_MARK  = 3'd6
    } t_op;

endpackage

// File: rtl/amg_req_if.sv
interface amg_req_if import amg_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            operation;
    logic [VTX_W-1:0]           row_vertex;
    logic [VTX_W-1:0]           col_vertex;
    logic signed [WEIGHT_W-1:0] weight_in;
    logic [MARK_W-1:0]          mark_in;

    modport source (
        output valid, operation, row_vertex, col_vertex, weight_in, mark_in,
        input  ready
    );
    modport sink (
        input  valid, operation, row_vertex, col_vertex, weight_in, mark_in,
        output ready
    );
endinterface

// File: rtl/amg_rsp_if.sv
interface amg_rsp_if import amg_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [WEIGHT_W-1:0] weight_out;
    logic                       edge_present;
    logic [COUNT_W-1:0]         neighbor;
    logic [MARK_W-1:0]          mark_out;
    logic                       bad_index;

    modport source (
        output valid, weight_out, edge_present, neighbor, mark_out, bad_index,
        input  ready
    );
    modport sink (
        input  valid, weight_out, edge_present, neighbor, mark_out, bad_index,
        output ready
    );
endinterface

// File: rtl/adjacency_matrix_graph_store_unit.sv
// Weighted directed graph store: a MAX_VERTICES x MAX_VERTICES matrix of signed
// 16-bit weights (zero means no edge) plus one 8-bit mark per vertex.
// Request channel i_req carries one operation per transaction: set, remove or
// query an edge, first or next nonzero neighbor in a row, read or write a mark.
// Response channel o_rsp returns exactly one transaction per request, in order.
// The APB port holds vertex_count at byte address 0; write it only while idle.
// Edge and mark writes and invalid requests pass through the EXEC and OUT
// states; edge queries and mark reads add RDWAIT between them, and a
// neighbor search adds SCAN. The search is set by the single matrix read
// port: one column is fetched per cycle and tested in the next cycle. One
// request is in flight at a time; i_req.ready is high only in the idle
// state, so no new request is taken until the last result is in the output register.
// A finished response waits in the output register while o_rsp.ready is low;
// the block then holds its result and stalls until the register is taken.
// After reset the block runs a clearing pass over the MAX_VERTICES*MAX_VERTICES
// entries (256 by default) that zeroes all weights and marks; no request is
// accepted meanwhile, while configuration writes are taken as ever.
module adjacency_matrix_graph_store_unit import amg_pkg::*; #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    amg_req_if.sink               i_req,
    amg_rsp_if.source             o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = $clog2(MAX_VERTICES);
    localparam logic [COUNT_W:0] COUNT_CAP =
        (MAX_VERTICES > 31) ? (COUNT_W+1)'(31) : (COUNT_W+1)'(MAX_VERTICES);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_SCAN,
        ST_OUT
    } t_state;

    t_state r_state;

    // Configuration
    logic [COUNT_W-1:0] r_vertex_count;
    logic [COUNT_W-1:0] active_n;

    // Latched request
    t_op                  r_op;
    logic [VTX_W-1:0]     r_row;
    logic [COUNT_W-1:0]   r_col;
    logic [WEIGHT_W-1:0]  r_weight;
    logic [MARK_W-1:0]    r_mark;

    // Scan pipeline
    logic                 r_chk_valid;
    logic [COUNT_W-1:0]   r_chk_col;

    // Result and output registers
    logic [WEIGHT_W-1:0]  r_wout;
    logic                 r_pres;
    logic [COUNT_W-1:0]   r_nb;
    logic [MARK_W-1:0]    r_mout;
    logic                 r_bad;
    logic                 r_out_valid;
    logic [WEIGHT_W-1:0]  r_out_wout;
    logic                 r_out_pres;
    logic [COUNT_W-1:0]   r_out_nb;
    logic [MARK_W-1:0]    r_out_mout;
    logic                 r_out_bad;

    // Storage
    logic [WEIGHT_W-1:0]  weight_mem [DEPTH];
    logic [MARK_W-1:0]    mark_mem   [MAX_VERTICES];
    logic [WEIGHT_W-1:0]  r_rd_data;
    logic [MARK_W-1:0]    r_mk_data;
    logic [AW-1:0]        r_clr_idx;

    logic                 row_ok;
    logic                 col_ok;
    logic                 cfg_wr;
    logic [AW-1:0]        mat_addr;
    logic [AW-1:0]        mat_waddr;
    logic                 mat_we;
    logic [WEIGHT_W-1:0]  mat_wdata;
    logic [MW-1:0]        mk_addr;
    logic [MW-1:0]        mk_waddr;
    logic                 mk_we;
    logic [MARK_W-1:0]    mk_wdata;

    // Effective vertex count, capped at the matrix size
    assign active_n = ({1'b0, r_vertex_count} > COUNT_CAP) ? COUNT_CAP[COUNT_W-1:0]
                                                           : r_vertex_count;
    assign row_ok   = ({1'b0, r_row} < active_n);
    assign col_ok   = (r_col < active_n);

    // APB register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_VERTEX_COUNT)
                  ? {{(CFG_DATA_W-COUNT_W){1'b0}}, r_vertex_count} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VERTEX_COUNT_RESET;
        end else if (cfg_wr && (paddr[2] == REG_VERTEX_COUNT)) begin
            r_vertex_count <= pwdata[COUNT_W-1:0];
        end
    end

    // Storage addressing: the latched row and current column select the entry
    assign mat_addr = AW'(int'(r_row) * MAX_VERTICES + int'(r_col));
    assign mk_addr  = MW'(r_row);

    always_comb begin
        mat_we    = 1'b0;
        mat_waddr = mat_addr;
        mat_wdata = '0;
        mk_we     = 1'b0;
        mk_waddr  = mk_addr;
        mk_wdata  = r_mark;
        if (r_state == ST_CLEAR) begin
            mat_we    = 1'b1;
            mat_waddr = r_clr_idx;
            mk_we     = (int'(r_clr_idx) < MAX_VERTICES);
            mk_waddr  = MW'(r_clr_idx);
            mk_wdata  = '0;
        end else if (r_state == ST_EXEC) begin
            mat_we    = row_ok && col_ok
                        && (r_op == OP_SET_EDGE || r_op == OP_REMOVE_EDGE);
            mat_wdata = (r_op == OP_SET_EDGE) ? r_weight : '0;
            mk_we     = row_ok && (r_op == OP_WRITE_MARK);
        end
    end

    // Weight matrix and mark memories, registered read
    always_ff @(posedge i_clk) begin
        if (mat_we) begin
            weight_mem[mat_waddr] <= mat_wdata;
        end
        r_rd_data <= weight_mem[mat_addr];
    end

    always_ff @(posedge i_clk) begin
        if (mk_we) begin
            mark_mem[mk_waddr] <= mk_wdata;
        end
        r_mk_data <= mark_mem[mk_addr];
    end

    assign i_req.ready = (r_state == ST_IDLE);

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.weight_out   = r_out_wout;
    assign o_rsp.edge_present = r_out_pres;
    assign o_rsp.neighbor     = r_out_nb;
    assign o_rsp.mark_out     = r_out_mout;
    assign o_rsp.bad_index    = r_out_bad;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
            r_chk_valid <= 1'b0;
        end else begin
            // drop the response once taken
            if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_idx <= r_clr_idx + AW'(1);
                    if (r_clr_idx == AW'(DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_op     <= t_op'(i_req.operation);
                        r_row    <= i_req.row_vertex;
                        r_col    <= {1'b0, i_req.col_vertex};
                        r_weight <= i_req.weight_in;
                        r_mark   <= i_req.mark_in;
                        r_state  <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_wout      <= '0;
                    r_pres      <= 1'b0;
                    r_nb        <= '0;
                    r_mout      <= '0;
                    r_bad       <= 1'b0;
                    r_chk_valid <= 1'b0;
                    r_state     <= ST_OUT;
                    unique case (r_op)
                        OP_SET_EDGE, OP_REMOVE_EDGE: begin
                            r_bad <= !(row_ok && col_ok);
                        end
                        OP_QUERY_EDGE: begin
                            r_bad <= !(row_ok && col_ok);
                            if (row_ok && col_ok) begin
                                r_state <= ST_RDWAIT;
                            end
                        end
                        OP_FIRST_NBR: begin
                            r_nb  <= active_n;
                            r_bad <= !row_ok;
                            r_col <= '0;
                            if (row_ok) begin
                                r_state <= ST_SCAN;
                            end
                        end
                        OP_NEXT_NBR: begin
                            r_nb  <= active_n;
                            r_bad <= !(row_ok && col_ok);
                            r_col <= r_col + COUNT_W'(1);
                            if (row_ok && col_ok) begin
                                r_state <= ST_SCAN;
                            end
                        end
                        OP_READ_MARK: begin
                            r_bad <= !row_ok;
                            if (row_ok) begin
                                r_state <= ST_RDWAIT;
                            end
                        end
                        OP_WRITE_MARK: begin
                            r_bad <= !row_ok;
                        end
                        default: begin
                            r_bad <= 1'b1;
                        end
                    endcase
                end
                ST_RDWAIT: begin
                    if (r_op == OP_QUERY_EDGE) begin
                        r_wout <= r_rd_data;
                        r_pres <= (r_rd_data != '0);
                    end else begin
                        r_mout <= r_mk_data;
                    end
                    r_state <= ST_OUT;
                end
                ST_SCAN: begin
                    // test the column fetched last cycle, fetch the next one
                    if (r_chk_valid && (r_rd_data != '0)) begin
                        r_nb    <= r_chk_col;
                        r_state <= ST_OUT;
                    end else if (r_col < active_n) begin
                        r_chk_valid <= 1'b1;
                        r_chk_col   <= r_col;
                        r_col       <= r_col + COUNT_W'(1);
                    end else begin
                        r_nb    <= active_n;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_wout  <= r_wout;
                        r_out_pres  <= r_pres;
                        r_out_nb    <= r_nb;
                        r_out_mout  <= r_mout;
                        r_out_bad   <= r_bad;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: test/graph_store_checker.sv
`timescale 1ns / 100ps

module graph_store_checker import amg_pkg::*; #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    amg_req_if                    i_req,
    amg_rsp_if                    i_rsp,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [CFG_DATA_W-1:0] i_pwdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] weight;
        logic                       present;
        logic [COUNT_W-1:0]         neighbor;
        logic [MARK_W-1:0]          mark;
        logic                       bad;
    } t_graph_rsp;

    // Shadow copy of the graph and the vertex count register
    logic signed [WEIGHT_W-1:0] edge_weight [MAX_VERTICES][MAX_VERTICES];
    logic [MARK_W-1:0]          vertex_mark [MAX_VERTICES];
    logic [COUNT_W-1:0]         vertex_count;
    t_graph_rsp                 expected_rsp_q [$];
    int                         mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    // Apply one operation to the shadow graph and return the response it yields
    function automatic t_graph_rsp apply_graph_op(
        input logic [OP_W-1:0]            op,
        input logic [VTX_W-1:0]           row,
        input logic [VTX_W-1:0]           col,
        input logic signed [WEIGHT_W-1:0] w,
        input logic [MARK_W-1:0]          mk
    );
        t_graph_rsp r;
        int         n;
        int         c;
        logic       row_ok;
        logic       col_ok;
        r      = '0;
        n      = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
        row_ok = int'(row) < n;
        col_ok = int'(col) < n;
        case (op)
            OP_SET_EDGE, OP_REMOVE_EDGE, OP_QUERY_EDGE: begin
                if (!row_ok || !col_ok) begin
                    r.bad = 1'b1;
                end else if (op == OP_SET_EDGE) begin
                    edge_weight[row][col] = w;
                end else if (op == OP_REMOVE_EDGE) begin
                    edge_weight[row][col] = '0;
                end else begin
                    r.weight  = edge_weight[row][col];
                    r.present = (edge_weight[row][col] != 0);
                end
            end
            OP_FIRST_NBR, OP_NEXT_NBR: begin
                // No-neighbor answer is the active count, also on a bad index
                r.neighbor = COUNT_W'(n);
                if (!row_ok || (op == OP_NEXT_NBR && !col_ok)) begin
                    r.bad = 1'b1;
                end else begin
                    c = (op == OP_NEXT_NBR) ? int'(col) + 1 : 0;
                    while (c < n && edge_weight[row][c] == 0) c++;
                    r.neighbor = COUNT_W'(c);
                end
            end
            OP_READ_MARK: begin
                if (!row_ok) r.bad = 1'b1;
                else         r.mark = vertex_mark[row];
            end
            OP_WRITE_MARK: begin
                if (!row_ok) r.bad = 1'b1;
                else         vertex_mark[row] = mk;
            end
            default: begin
                r.bad = 1'b1;
            end
        endcase
        return r;
    endfunction

    // Track register writes, predict each request and check each response
    always @(posedge i_clk) begin
        t_graph_rsp got;
        t_graph_rsp exp_rsp;
        if (!i_rst_n) begin
            foreach (edge_weight[r, c]) edge_weight[r][c] = '0;
            foreach (vertex_mark[v]) vertex_mark[v] = '0;
            vertex_count = VERTEX_COUNT_RESET;
            expected_rsp_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr[2] == REG_VERTEX_COUNT) begin
                vertex_count = i_pwdata[COUNT_W-1:0];
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got.weight   = i_rsp.weight_out;
                got.present  = i_rsp.edge_present;
                got.neighbor = i_rsp.neighbor;
                got.mark     = i_rsp.mark_out;
                got.bad      = i_rsp.bad_index;
                if (expected_rsp_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected response: expected none, actual weight=%0d",
                             $time, got.weight,
                             " present=%0b neighbor=%0d mark=%0d bad=%0b",
                             got.present, got.neighbor, got.mark, got.bad);
                end else begin
                    exp_rsp = expected_rsp_q.pop_front();
                    if (got !== exp_rsp) begin
                        mismatch_count++;
                        $display("%0t: response mismatch: expected weight=%0d", $time,
                                 exp_rsp.weight,
                                 " present=%0b neighbor=%0d mark=%0d bad=%0b",
                                 exp_rsp.present, exp_rsp.neighbor, exp_rsp.mark,
                                 exp_rsp.bad,
                                 ", actual weight=%0d present=%0b neighbor=%0d",
                                 got.weight, got.present, got.neighbor,
                                 " mark=%0d bad=%0b", got.mark, got.bad);
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                expected_rsp_q.push_back(apply_graph_op(i_req.operation, i_req.row_vertex,
                                                        i_req.col_vertex, i_req.weight_in,
                                                        i_req.mark_in));
            end
        end
        o_pending <= expected_rsp_q.size();
    end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import amg_pkg::*;

    localparam int MAX_V = 16;
    localparam logic [OP_W-1:0]       OP_INVALID        = 3'd7;
    localparam logic [CFG_ADDR_W-1:0] VERTEX_COUNT_ADDR = {REG_VERTEX_COUNT, 2'b00};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int                    send_idle_pct = 0;
    int                    rsp_stall_pct = 0;
    int                    fail_count;
    int                    pending;
    logic [COUNT_W-1:0]    cur_count = VERTEX_COUNT_RESET;

    amg_req_if req ();
    amg_rsp_if rsp ();

    adjacency_matrix_graph_store_unit #(.MAX_VERTICES(MAX_V)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    graph_store_checker #(.MAX_VERTICES(MAX_V)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .i_rsp        (rsp),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Give up if the run hangs
    initial begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Stall the response channel at the current rate
    always @(posedge i_clk) begin
        if (!i_rst_n) rsp.ready <= 1'b0;
        else          rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // Issue one request transaction, with random idle cycles ahead of it
    task automatic issue_op(
        input logic [OP_W-1:0]            op,
        input logic [VTX_W-1:0]           row,
        input logic [VTX_W-1:0]           col,
        input logic signed [WEIGHT_W-1:0] w,
        input logic [MARK_W-1:0]          mk
    );
        while ($urandom_range(99) < send_idle_pct) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid      <= 1'b1;
        req.operation  <= op;
        req.row_vertex <= row;
        req.col_vertex <= col;
        req.weight_in  <= w;
        req.mark_in    <= mk;
        do @(posedge i_clk); while (!req.ready);
    endtask

    // Drop valid and wait until every response is in, then let the block settle
    task automatic drain();
        req.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (24) @(posedge i_clk);
    endtask

    // Write the vertex count with random junk in the unused upper bits
    task automatic write_vertex_count(input logic [COUNT_W-1:0] cnt);
        logic [CFG_DATA_W-1:0] data;
        data              = $urandom();
        data[COUNT_W-1:0] = cnt;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= VERTEX_COUNT_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        cur_count  = cnt;
    endtask

    // Mostly in-range vertices, some anywhere in the index field
    function automatic logic [VTX_W-1:0] pick_vertex();
        int eff;
        eff = (cur_count > MAX_V) ? MAX_V : int'(cur_count);
        if (eff == 0 || $urandom_range(99) < 10) return VTX_W'($urandom_range(15));
        return VTX_W'($urandom_range(eff - 1));
    endfunction

    // Favor zero and the extremes so edges come and go
    function automatic logic signed [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(9))
            0, 1, 2: return '0;
            3:       return 16'sh7FFF;
            4:       return 16'sh8000;
            5:       return -16'sd1;
            default: return WEIGHT_W'($urandom());
        endcase
    endfunction

    // Reprogram the count while idle, then run a random mix of operations
    task automatic run_phase(input logic [COUNT_W-1:0] cnt, input int send_pct,
                             input int stall_pct, input int n_ops);
        int              sel;
        logic [OP_W-1:0] op;
        drain();
        write_vertex_count(cnt);
        send_idle_pct = send_pct;
        rsp_stall_pct = stall_pct;
        repeat (n_ops) begin
            sel = $urandom_range(99);
            if      (sel < 30) op = OP_SET_EDGE;
            else if (sel < 38) op = OP_REMOVE_EDGE;
            else if (sel < 55) op = OP_QUERY_EDGE;
            else if (sel < 67) op = OP_FIRST_NBR;
            else if (sel < 82) op = OP_NEXT_NBR;
            else if (sel < 89) op = OP_READ_MARK;
            else if (sel < 96) op = OP_WRITE_MARK;
            else               op = OP_INVALID;
            issue_op(op, pick_vertex(), pick_vertex(), pick_weight(),
                     MARK_W'($urandom()));
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        req.valid      <= 1'b0;
        req.operation  <= '0;
        req.row_vertex <= '0;
        req.col_vertex <= '0;
        req.weight_in  <= '0;
        req.mark_in    <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Edge extremes, neighbor walks across a row and mark corners
        write_vertex_count(5'd16);
        issue_op(OP_SET_EDGE,    4'd0,  4'd0,  16'sh7FFF, 8'h00);
        issue_op(OP_SET_EDGE,    4'd0,  4'd15, 16'sh8000, 8'h00);
        issue_op(OP_SET_EDGE,    4'd15, 4'd15, -16'sd1,   8'h00);
        issue_op(OP_QUERY_EDGE,  4'd0,  4'd0,  '0,        8'h00);
        issue_op(OP_QUERY_EDGE,  4'd0,  4'd15, '0,        8'h00);
        issue_op(OP_QUERY_EDGE,  4'd15, 4'd15, '0,        8'h00);
        issue_op(OP_QUERY_EDGE,  4'd1,  4'd1,  '0,        8'h00);
        issue_op(OP_FIRST_NBR,   4'd0,  4'd0,  '0,        8'h00);
        issue_op(OP_NEXT_NBR,    4'd0,  4'd0,  '0,        8'h00);
        issue_op(OP_NEXT_NBR,    4'd0,  4'd15, '0,        8'h00);
        issue_op(OP_FIRST_NBR,   4'd1,  4'd0,  '0,        8'h00);
        issue_op(OP_REMOVE_EDGE, 4'd0,  4'd0,  16'sh1234, 8'h00);
        issue_op(OP_QUERY_EDGE,  4'd0,  4'd0,  '0,        8'h00);
        issue_op(OP_FIRST_NBR,   4'd0,  4'd0,  '0,        8'h00);
        issue_op(OP_WRITE_MARK,  4'd15, 4'd0,  '0,        8'hFF);
        issue_op(OP_WRITE_MARK,  4'd0,  4'd0,  '0,        8'h5A);
        issue_op(OP_READ_MARK,   4'd15, 4'd0,  '0,        8'h00);
        issue_op(OP_READ_MARK,   4'd0,  4'd0,  '0,        8'h00);
        issue_op(OP_INVALID,     4'd15, 4'd15, -16'sd1,   8'hFF);

        // Out-of-range indices with a reduced count, and the end-of-row case
        drain();
        write_vertex_count(5'd4);
        issue_op(OP_SET_EDGE,    4'd5,  4'd1,  16'sh0077, 8'h00);
        issue_op(OP_QUERY_EDGE,  4'd1,  4'd9,  '0,        8'h00);
        issue_op(OP_FIRST_NBR,   4'd7,  4'd0,  '0,        8'h00);
        issue_op(OP_NEXT_NBR,    4'd2,  4'd12, '0,        8'h00);
        issue_op(OP_NEXT_NBR,    4'd3,  4'd3,  '0,        8'h00);
        issue_op(OP_READ_MARK,   4'd4,  4'd0,  '0,        8'h00);
        issue_op(OP_WRITE_MARK,  4'd10, 4'd0,  '0,        8'hC3);

        // Random phases over counts and idle patterns
        run_phase(5'd16, 0,  0,  220);
        run_phase(5'd1,  47, 0,  60);
        run_phase(5'd31, 47, 0,  200);
        run_phase(5'd0,  0,  47, 40);
        run_phase(5'd9,  0,  47, 250);
        run_phase(5'd16, 8,  8,  250);
        run_phase(5'd3,  8,  8,  100);
        run_phase(5'd31, 0,  0,  180);
        drain();

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
